// ===== rtl/core/pdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdbd_pkg: shared definitions for the panorama detection box decoder
// Widths, register indexes, sequencer states and edge saturation.
// ----------------------------------------------------------------------------
package pdbd_pkg;

    localparam int MAX_CLASSES    = 256;
    localparam int MAX_DETECTIONS = 4096;

    localparam int CNT_W     = $clog2(MAX_CLASSES + 1);
    localparam int LIST_W    = $clog2(MAX_DETECTIONS + 1);
    localparam int CLASS_W   = 8;
    localparam int ENTRY_W   = 12;
    localparam int SCORE_W   = 16;
    localparam int BOX_W     = 17;
    localparam int EDGE_W    = 20;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = 34;
    localparam int QUO_W     = NUM_W + 1;
    localparam int SUM_W     = 37;
    localparam int DCNT_W    = $clog2(NUM_W);

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 120;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEAM_GAP  = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd32768;
    localparam logic [CFG_W-1:0] TILE_SIZE_RST = 16'd416;
    localparam logic [CFG_W-1:0] SEAM_GAP_RST  = 16'd0;

    localparam logic [BOX_W-1:0] Q_ONE  = 17'h10000;
    localparam logic [BOX_W-1:0] Q_HALF = 17'h08000;

    localparam logic signed [SUM_W-1:0] EDGE_HI = SUM_W'((1 << (EDGE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] EDGE_LO = ~EDGE_HI;

    typedef struct packed {
        logic               emit;
        logic               upper;
        logic [ENTRY_W-1:0] entry;
        logic [CLASS_W-1:0] class_idx;
        logic [SCORE_W-1:0] best;
    } pdbd_close_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_Y,
        ST_START_Y,
        ST_DIV_Y,
        ST_MUL_H,
        ST_START_H,
        ST_DIV_H,
        ST_EDGE
    } pdbd_state_t;

    function automatic logic signed [EDGE_W-1:0] sat_edge(input logic signed [SUM_W-1:0] v);
        if (v < EDGE_LO) begin
            return EDGE_LO[EDGE_W-1:0];
        end else if (v > EDGE_HI) begin
            return EDGE_HI[EDGE_W-1:0];
        end
        return v[EDGE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/panorama_detection_box_decode.sv =====
// ----------------------------------------------------------------------------
// panorama_detection_box_decode: class arg-max and tiled box edge decoder
// Accepts one class score per word and emits at most one box per detection.
// ----------------------------------------------------------------------------
// A score word that does not close a detection, or closes one without
// emitting a box, is taken at once and the next word may follow without
// a gap. A closing word that emits a box keeps the input stalled through
// two multiplies on one shared 16x17 multiplier and two 34-bit divisions
// on one serial divider that yields one quotient bit per cycle, each
// division after its own start step, then through forming the edges and
// loading the output register; that last step waits while an earlier box
// has not been taken. Words that emit nothing are accepted while a box
// waits at the output. Configuration is taken in every cycle and must only
// be changed while the block is idle.
module panorama_detection_box_decode (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // score [15:0], box_x [32:16], box_y [49:33], box_w [66:50], box_h [83:67]
    input  logic [pdbd_pkg::S_TDATA_W-1:0]       s_tdata,
    // frame_start [0]
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // class_index [7:0], entry_index [19:8], left_edge [39:20], right_edge [59:40],
    // top_edge [79:60], bottom_edge [99:80], best_probability [115:100]
    output logic [pdbd_pkg::M_TDATA_W-1:0]       m_tdata,
    // upper_half [0]
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdbd_pkg::CFG_W-1:0]           cfg_data
);
    import pdbd_pkg::*;

    pdbd_state_t state_reg, state_next;

    logic [CFG_W-1:0] thr_reg, tile_reg, gap_reg;

    logic [SCORE_W-1:0] s_score;
    logic [BOX_W-1:0]   s_bx, s_by, s_bw, s_bh;
    logic               s_accept;

    pdbd_close_t close, close_reg;
    logic [BOX_W-1:0] bx_reg, by_reg, bw_reg, bh_reg;

    logic               mul_sel_h, lower_y, div_start, out_load;
    logic [BOX_W-1:0]   mul_b;
    logic [NUM_W-2:0]   mul_prod;
    logic [NUM_W-1:0]   prod_reg;
    logic [CFG_W:0]     sg_sum;
    logic [NUM_W:0]     num_s, num_neg_v;
    logic [NUM_W-1:0]   num_abs;
    logic [CFG_W-1:0]   den;

    logic                     div_busy, div_done;
    logic signed [QUO_W-1:0]  div_quot;
    logic signed [QUO_W-1:0]  y_reg;

    logic [BOX_W:0]           x_lo;
    logic signed [SUM_W-1:0]  x_s, hw_s, y_s, hh_s, one_s;
    logic signed [SUM_W-1:0]  l_s, r_s, t_s, b_s;

    logic                     m_valid_reg;
    logic [CLASS_W-1:0]       m_class_reg;
    logic [ENTRY_W-1:0]       m_entry_reg;
    logic signed [EDGE_W-1:0] m_left_reg, m_right_reg, m_top_reg, m_bottom_reg;
    logic [SCORE_W-1:0]       m_best_reg;
    logic                     m_upper_reg;

    assign s_score = s_tdata[15:0];
    assign s_bx    = s_tdata[32:16];
    assign s_by    = s_tdata[49:33];
    assign s_bw    = s_tdata[66:50];
    assign s_bh    = s_tdata[83:67];

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THRESHOLD_RST;
            tile_reg <= TILE_SIZE_RST;
            gap_reg  <= SEAM_GAP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_data;
                CFG_TILE_SIZE: tile_reg <= cfg_data;
                CFG_SEAM_GAP:  gap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    pdbd_argmax u_argmax (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .score       (s_score),
        .last        (s_tlast),
        .frame_start (s_tuser),
        .box_y       (s_by),
        .threshold   (thr_reg),
        .close       (close)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_accept && close.emit) state_next = ST_MUL_Y;
            ST_MUL_Y:   state_next = ST_START_Y;
            ST_START_Y: state_next = ST_DIV_Y;
            ST_DIV_Y:   if (div_done) state_next = ST_MUL_H;
            ST_MUL_H:   state_next = ST_START_H;
            ST_START_H: state_next = ST_DIV_H;
            ST_DIV_H:   if (div_done) state_next = ST_EDGE;
            ST_EDGE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        mul_sel_h = 1'b0;
        div_start = 1'b0;
        lower_y   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:    s_tready  = 1'b1;
            ST_MUL_H:   mul_sel_h = 1'b1;
            ST_START_Y: begin
                div_start = 1'b1;
                lower_y   = !close_reg.upper;
            end
            ST_START_H: div_start = 1'b1;
            ST_EDGE:    out_load  = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && close.emit) begin
            close_reg <= close;
            bx_reg    <= s_bx;
            by_reg    <= s_by;
            bw_reg    <= s_bw;
            bh_reg    <= s_bh;
        end
    end

    assign mul_b    = mul_sel_h ? bh_reg : by_reg;
    assign mul_prod = tile_reg * mul_b;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL_Y || state_reg == ST_MUL_H) begin
            prod_reg <= {mul_prod, 1'b0};
        end
    end

    always_comb begin
        sg_sum    = {1'b0, tile_reg} + {1'b0, gap_reg};
        num_s     = {1'b0, prod_reg} - (lower_y ? {2'b00, sg_sum, 16'h0000} : '0);
        num_neg_v = -num_s;
        num_abs   = num_s[NUM_W] ? num_neg_v[NUM_W-1:0] : num_s[NUM_W-1:0];
        den       = (gap_reg >= tile_reg) ? CFG_W'(1) : tile_reg - gap_reg;
    end

    pdbd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_abs),
        .neg     (num_s[NUM_W]),
        .den     (den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV_Y && div_done) begin
            y_reg <= div_quot;
        end
    end

    always_comb begin
        x_lo = {1'b0, bx_reg} + (BOX_W + 1)'(Q_HALF);
        if (x_lo > (BOX_W + 1)'(Q_ONE)) begin
            x_lo = x_lo - (BOX_W + 1)'(Q_ONE);
        end
        if (close_reg.upper) begin
            x_lo = {1'b0, bx_reg};
        end
        one_s = SUM_W'(Q_ONE);
        x_s   = SUM_W'(x_lo);
        hw_s  = SUM_W'(bw_reg[BOX_W-1:1]);
        y_s   = {{(SUM_W - QUO_W){y_reg[QUO_W-1]}}, y_reg};
        hh_s  = SUM_W'(div_quot[QUO_W-2:1]);

        l_s = x_s - hw_s;
        r_s = x_s + hw_s;
        t_s = y_s - hh_s;
        b_s = y_s + hh_s;
        if (close_reg.upper) begin
            if (l_s < 0) l_s = '0;
            if (r_s > one_s) r_s = one_s;
        end
        if (t_s < 0) t_s = '0;
        if (b_s > one_s) b_s = one_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_class_reg  <= close_reg.class_idx;
            m_entry_reg  <= close_reg.entry;
            m_best_reg   <= close_reg.best;
            m_upper_reg  <= close_reg.upper;
            m_left_reg   <= sat_edge(l_s);
            m_right_reg  <= sat_edge(r_s);
            m_top_reg    <= sat_edge(t_s);
            m_bottom_reg <= sat_edge(b_s);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_upper_reg;
    assign m_tdata  = {4'h0, m_best_reg, m_bottom_reg, m_top_reg, m_right_reg,
                       m_left_reg, m_entry_reg, m_class_reg};

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("divider busy while input is open");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_Y || state_reg == ST_DIV_H))
        else $error("division completed outside a divide step");

    a_emit_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && close.emit |=> state_reg == ST_MUL_Y)
        else $error("emitting word did not start the box sequence");

    a_upper_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_left_reg[EDGE_W-1] &&
            (m_right_reg <= $signed(EDGE_W'(Q_ONE))))
        else $error("upper tile horizontal edge outside unit range");

endmodule

// ===== rtl/core/pdbd_argmax.sv =====
// ----------------------------------------------------------------------------
// pdbd_argmax: running arg-max and tile list counters
// Tracks the first highest score of a detection and decides on the closing
// score whether a box is emitted and where it goes in its tile list.
// ----------------------------------------------------------------------------
module pdbd_argmax (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [pdbd_pkg::SCORE_W-1:0]  score,
    input  logic                          last,
    input  logic                          frame_start,
    input  logic [pdbd_pkg::BOX_W-1:0]    box_y,
    input  logic [pdbd_pkg::CFG_W-1:0]    threshold,
    output pdbd_pkg::pdbd_close_t         close
);
    import pdbd_pkg::*;

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_class_reg, best_class_next;
    logic [CNT_W-1:0]   class_cnt_reg, class_cnt_next;
    logic [LIST_W-1:0]  upper_cnt_reg, upper_cnt_next;
    logic [LIST_W-1:0]  lower_cnt_reg, lower_cnt_next;

    logic [SCORE_W-1:0] bs_eff, bs_upd;
    logic [CLASS_W-1:0] bc_eff, bc_upd;
    logic [CNT_W-1:0]   cnt_eff, cnt_upd;
    logic [LIST_W-1:0]  uc_eff, lc_eff;
    logic               upper, full, emit;

    always_comb begin
        bs_eff  = frame_start ? '0 : best_score_reg;
        bc_eff  = frame_start ? '0 : best_class_reg;
        cnt_eff = frame_start ? '0 : class_cnt_reg;
        uc_eff  = frame_start ? '0 : upper_cnt_reg;
        lc_eff  = frame_start ? '0 : lower_cnt_reg;

        bs_upd  = bs_eff;
        bc_upd  = bc_eff;
        cnt_upd = cnt_eff;
        if (cnt_eff < CNT_W'(MAX_CLASSES)) begin
            if (cnt_eff == '0 || score > bs_eff) begin
                bs_upd = score;
                bc_upd = CLASS_W'(cnt_eff);
            end
            cnt_upd = cnt_eff + CNT_W'(1);
        end

        upper = !(box_y > Q_HALF);
        full  = upper ? (uc_eff >= LIST_W'(MAX_DETECTIONS))
                      : (lc_eff >= LIST_W'(MAX_DETECTIONS));
        emit  = last && (bs_upd > threshold) && !full;

        close.emit      = emit;
        close.upper     = upper;
        close.entry     = upper ? ENTRY_W'(uc_eff) : ENTRY_W'(lc_eff);
        close.class_idx = bc_upd;
        close.best      = bs_upd;

        upper_cnt_next  = uc_eff + LIST_W'(emit && upper);
        lower_cnt_next  = lc_eff + LIST_W'(emit && !upper);
        best_score_next = last ? '0 : bs_upd;
        best_class_next = last ? '0 : bc_upd;
        class_cnt_next  = last ? '0 : cnt_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
            upper_cnt_reg  <= '0;
            lower_cnt_reg  <= '0;
        end else if (accept) begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            class_cnt_reg  <= class_cnt_next;
            upper_cnt_reg  <= upper_cnt_next;
            lower_cnt_reg  <= lower_cnt_next;
        end
    end

endmodule

// ===== rtl/core/pdbd_div.sv =====
// ----------------------------------------------------------------------------
// pdbd_div: serial restoring divider
// Divides a magnitude by a 16-bit divisor, one quotient bit per cycle, and
// applies the sign so that the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module pdbd_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [pdbd_pkg::NUM_W-1:0]          num,
    input  logic                                neg,
    input  logic [pdbd_pkg::CFG_W-1:0]          den,
    output logic                                busy,
    output logic                                done,
    output logic signed [pdbd_pkg::QUO_W-1:0]   quot
);
    import pdbd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [CFG_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [CFG_W:0]    trial, diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            neg_next  = neg;
        end else if (busy_reg) begin
            rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== bench/tb_panorama_detection_box_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_panorama_detection_box_decode: self-checking bench for the box decoder
// Streams class scores of detections into the block and predicts the arg-max,
// threshold decision, tile selection, list position and clamped edges of
// every box. Each box leaving the block is checked field by field against the
// oldest prediction. Covers register settings at their extremes, frame and
// class-count corner cases, random stalls on both sides, one long output
// hold-off, and list positions in both tiles across a new frame.
// ----------------------------------------------------------------------------
module tb_panorama_detection_box_decode;
    import pdbd_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 500;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               class_last;
        logic               frame_start;
        logic [BOX_W-1:0]   box_x;
        logic [BOX_W-1:0]   box_y;
        logic [BOX_W-1:0]   box_w;
        logic [BOX_W-1:0]   box_h;
    } score_word_t;

    typedef struct {
        logic [CLASS_W-1:0] class_index;
        logic               upper_half;
        logic [ENTRY_W-1:0] entry_index;
        logic [EDGE_W-1:0]  left_edge;
        logic [EDGE_W-1:0]  right_edge;
        logic [EDGE_W-1:0]  top_edge;
        logic [EDGE_W-1:0]  bottom_edge;
        logic [SCORE_W-1:0] best_probability;
    } decoded_box_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_THRESHOLD;
    logic [CFG_W-1:0]       cfg_data = '0;

    score_word_t  pending_words[$];
    decoded_box_t expected_boxes[$];
    score_word_t  offered_word;
    logic         word_taken = 1'b0;
    logic         cfg_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         hold_arm = 1'b0;
    int           hold_count = 0;
    logic         holding;
    int           cycle_count = 0;
    int           error_count = 0;
    logic [SCORE_W-1:0] prev_score = '0;

    // predictor copy of registers and state
    logic [CFG_W-1:0]   threshold_val = THRESHOLD_RST;
    logic [CFG_W-1:0]   tile_px = TILE_SIZE_RST;
    logic [CFG_W-1:0]   gap_px = SEAM_GAP_RST;
    logic [SCORE_W-1:0] best_score = '0;
    logic [CLASS_W-1:0] best_class = '0;
    logic [CNT_W-1:0]   class_count = '0;
    logic [LIST_W-1:0]  upper_count = '0;
    logic [LIST_W-1:0]  lower_count = '0;

    panorama_detection_box_decode i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic void clear_argmax();
        best_score  = '0;
        best_class  = '0;
        class_count = '0;
    endfunction

    function automatic logic [EDGE_W-1:0] clip_edge(input longint v);
        if (v < -524288) begin
            return 20'h80000;
        end else if (v > 524287) begin
            return 20'h7FFFF;
        end
        return v[EDGE_W-1:0];
    endfunction

    function automatic bit decode_word(input score_word_t w, output decoded_box_t box);
        longint s_len, g_len, d_len, bx, by, bw, bh, x, y, h, hw, hh, l, r, t, b;
        bit upper;
        logic [ENTRY_W-1:0] entry;
        box = '{default: '0};
        if (w.frame_start) begin
            upper_count = '0;
            lower_count = '0;
            clear_argmax();
        end
        if (class_count < MAX_CLASSES) begin
            if (class_count == 0 || w.score > best_score) begin
                best_score = w.score;
                best_class = class_count[CLASS_W-1:0];
            end
            class_count = class_count + 1'b1;
        end
        if (!w.class_last) return 1'b0;
        if (best_score <= threshold_val) begin
            clear_argmax();
            return 1'b0;
        end
        upper = (w.box_y <= Q_HALF);
        if (upper) begin
            if (upper_count >= MAX_DETECTIONS) begin
                clear_argmax();
                return 1'b0;
            end
            entry = upper_count[ENTRY_W-1:0];
            upper_count = upper_count + 1'b1;
        end else begin
            if (lower_count >= MAX_DETECTIONS) begin
                clear_argmax();
                return 1'b0;
            end
            entry = lower_count[ENTRY_W-1:0];
            lower_count = lower_count + 1'b1;
        end
        s_len = longint'(tile_px);
        g_len = longint'(gap_px);
        d_len = (gap_px >= tile_px) ? 1 : s_len - g_len;
        bx = longint'(w.box_x);
        by = longint'(w.box_y);
        bw = longint'(w.box_w);
        bh = longint'(w.box_h);
        if (upper) begin
            x = bx;
            y = (2 * s_len * by) / d_len;
        end else begin
            x = bx + 32768;
            if (x > 65536) x = x - 65536;
            y = (2 * s_len * by - (s_len + g_len) * 65536) / d_len;
        end
        h  = (2 * s_len * bh) / d_len;
        hw = bw / 2;
        hh = h / 2;
        l  = x - hw;
        r  = x + hw;
        t  = y - hh;
        b  = y + hh;
        if (upper) begin
            if (l < 0) l = 0;
            if (r > 65536) r = 65536;
        end
        if (t < 0) t = 0;
        if (b > 65536) b = 65536;
        box.class_index      = best_class;
        box.upper_half       = upper;
        box.entry_index      = entry;
        box.left_edge        = clip_edge(l);
        box.right_edge       = clip_edge(r);
        box.top_edge         = clip_edge(t);
        box.bottom_edge      = clip_edge(b);
        box.best_probability = best_score;
        clear_argmax();
        return 1'b1;
    endfunction

    // input side: offer words from the queue
    always @(negedge aclk) begin : word_driver
        score_word_t w;
        logic        v;
        v = s_tvalid;
        if (!aresetn) begin
            v = 1'b0;
        end else begin
            if (word_taken) v = 1'b0;
            if (!v && pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                v = 1'b1;
                offered_word <= w;
                s_tdata <= {4'b0, w.box_h, w.box_w, w.box_y, w.box_x, w.score};
                s_tuser <= w.frame_start;
                s_tlast <= w.class_last;
            end
        end
        s_tvalid <= v;
    end

    always @(posedge aclk) begin : word_monitor
        decoded_box_t box;
        word_taken <= aresetn && s_tvalid && s_tready;
        cfg_taken  <= aresetn && cfg_valid && cfg_ready;
        if (aresetn && s_tvalid && s_tready) begin
            if (decode_word(offered_word, box)) expected_boxes.push_back(box);
        end
    end

    // output side
    assign holding = hold_arm && hold_count < HOLD_CYCLES;

    always @(negedge aclk) begin : hold_counter
        if (holding) hold_count <= hold_count + 1;
    end

    always @(negedge aclk) begin : box_receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !holding && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [EDGE_W-1:0] want,
                               input logic [EDGE_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : box_monitor
        decoded_box_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_boxes.size() == 0) begin
                error_count++;
                $error("unexpected box: tdata 0x%0h tuser %0b", m_tdata, m_tuser);
            end else begin
                want = expected_boxes.pop_front();
                check_field("class_index", EDGE_W'(want.class_index),
                            EDGE_W'(m_tdata[7:0]));
                check_field("upper_half", EDGE_W'(want.upper_half), EDGE_W'(m_tuser));
                check_field("entry_index", EDGE_W'(want.entry_index),
                            EDGE_W'(m_tdata[19:8]));
                check_field("left_edge", want.left_edge, m_tdata[39:20]);
                check_field("right_edge", want.right_edge, m_tdata[59:40]);
                check_field("top_edge", want.top_edge, m_tdata[79:60]);
                check_field("bottom_edge", want.bottom_edge, m_tdata[99:80]);
                check_field("best_probability", EDGE_W'(want.best_probability),
                            EDGE_W'(m_tdata[115:100]));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_word(input int score, input bit last, input bit fstart,
                             input int bx, input int by, input int bw, input int bh);
        score_word_t w;
        w.score       = score[SCORE_W-1:0];
        w.class_last  = last;
        w.frame_start = fstart;
        w.box_x       = bx[BOX_W-1:0];
        w.box_y       = by[BOX_W-1:0];
        w.box_w       = bw[BOX_W-1:0];
        w.box_h       = bh[BOX_W-1:0];
        pending_words.push_back(w);
    endtask

    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom_range(65536);
        if (pick < 55) return $urandom_range(32840, 32700);
        if (pick < 65) begin
            case ($urandom_range(3))
                0: return 0;
                1: return 65536;
                2: return 131071;
                default: return 1;
            endcase
        end
        if (pick < 80) return $urandom_range(131071, 65537);
        return $urandom_range(8192);
    endfunction

    function automatic int rand_score();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) prev_score = '0;
        else if (pick < 20) prev_score = '1;
        else if (pick >= 30) prev_score = SCORE_W'($urandom_range(65535));
        return int'(prev_score);
    endfunction

    task automatic push_detection(input int n_scores);
        bit fstart;
        for (int i = 0; i < n_scores; i++) begin
            fstart = (i == 0 && $urandom_range(99) < 8) || $urandom_range(199) == 0;
            push_word(rand_score(), i == n_scores - 1, fstart,
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic run_chunk(input int n_words);
        int pushed;
        int pick;
        int n_scores;
        pushed = 0;
        while (pushed < n_words) begin
            pick = $urandom_range(99);
            if (pick < 85) n_scores = $urandom_range(5, 1);
            else if (pick < 99) n_scores = $urandom_range(20, 6);
            else n_scores = $urandom_range(300, 250);
            push_detection(n_scores);
            pushed += n_scores;
        end
    endtask

    // winner at the last counted class, a higher score past the limit
    task automatic push_long_detection();
        int score;
        for (int i = 0; i < 300; i++) begin
            if (i == 255) score = 60000;
            else if (i == 280) score = 65535;
            else score = $urandom_range(59999);
            push_word(score, i == 299, 1'b0,
                      rand_coord(), $urandom_range(65536), rand_coord(), rand_coord());
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_boxes.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD: threshold_val = val;
            CFG_TILE_SIZE: tile_px = val;
            CFG_SEAM_GAP:  gap_px = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int thr, input int tile, input int gap);
        wait_idle();
        write_reg(CFG_THRESHOLD, thr[CFG_W-1:0]);
        write_reg(CFG_TILE_SIZE, tile[CFG_W-1:0]);
        write_reg(CFG_SEAM_GAP, gap[CFG_W-1:0]);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 53;

        push_word(65535, 1, 1, 32768, 16384, 8192, 8192);
        push_word(32768, 1, 0, 1000, 1000, 1000, 1000);
        push_word(32769, 1, 0, 65536, 65536, 65536, 65536);
        push_word(0, 0, 0, 0, 0, 0, 0);
        push_word(50000, 0, 0, 0, 0, 0, 0);
        push_word(50000, 0, 0, 0, 0, 0, 0);
        push_word(10000, 1, 0, 100, 32769, 200, 300);
        push_word(0, 1, 0, 43690, 21845, 43690, 21845);
        push_word(60000, 0, 0, 0, 0, 0, 0);
        push_word(40000, 0, 1, 0, 0, 0, 0);
        push_word(35000, 1, 0, 5000, 20000, 3000, 3000);
        push_word(65535, 1, 0, 131071, 131071, 131071, 131071);
        push_word(65535, 1, 0, 0, 0, 0, 0);
        push_word(40000, 1, 0, 1, 32768, 65536, 2);
        push_word(40000, 1, 0, 65535, 32769, 1, 65536);
        push_long_detection();
        run_chunk(60);

        apply_setting(0, 416, 32);
        hold_arm = 1'b1;
        push_long_detection();
        run_chunk(100);

        apply_setting(20000, 1, 0);
        run_chunk(80);

        send_idle_pct = 53;
        recv_idle_pct = 10;
        apply_setting(40000, 65535, 65534);
        run_chunk(80);

        apply_setting(65535, 300, 300);
        run_chunk(30);

        apply_setting(10000, 608, 100);
        run_chunk(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(0, 65535, 0);
        run_chunk(80);

        // add entries to the upper list, then the lower list, then restart the frame
        apply_setting(0, 416, 0);
        for (int i = 0; i < 20; i++) begin
            push_word($urandom_range(65535, 1), 1, i == 0,
                      rand_coord(), $urandom_range(32768), rand_coord(), rand_coord());
        end
        push_word(65535, 1, 0, rand_coord(), 65536, rand_coord(), rand_coord());
        push_word(1, 1, 0, rand_coord(), 40000, rand_coord(), rand_coord());
        push_word(12345, 1, 1, rand_coord(), 100, rand_coord(), rand_coord());

        wait_idle();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
